// File: hdl/cmi_pkg.sv
`timescale 1ns / 1ps

package cmi_pkg;

    // Width of one complex component and of the magnitude
    localparam int COMPONENT_WIDTH = 16;
    // Sum of squares and root datapath width
    localparam int SUM_WIDTH = 2 * COMPONENT_WIDTH;
    // One root cell per result bit
    localparam int CELL_COUNT = COMPONENT_WIDTH;
    // abs, square and sum registers ahead of the cell chain
    localparam int FRONT_STAGES = 3;
    localparam int LATENCY = FRONT_STAGES + CELL_COUNT;
    // First trial bit of the root: bit SUM_WIDTH-2
    localparam logic [SUM_WIDTH-1:0] TRIAL_START =
        {2'b01, {(SUM_WIDTH - 2){1'b0}}};

    // What travels from one root cell to the next
    typedef struct packed {
        logic                 valid;
        logic [SUM_WIDTH-1:0] rem;
        logic [SUM_WIDTH-1:0] root;
        logic [SUM_WIDTH-1:0] trial;
    } stage_t;

endpackage

// File: hdl/cmi_square.sv
`timescale 1ns / 1ps

module cmi_square
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    input  logic signed [cmi_pkg::COMPONENT_WIDTH-1:0]  real_part,
    input  logic signed [cmi_pkg::COMPONENT_WIDTH-1:0]  imag_part,
    output cmi_pkg::stage_t                             stage_out
);

    logic [cmi_pkg::COMPONENT_WIDTH-1:0] re_abs_next;
    logic [cmi_pkg::COMPONENT_WIDTH-1:0] im_abs_next;
    logic [cmi_pkg::COMPONENT_WIDTH-1:0] re_abs_reg;
    logic [cmi_pkg::COMPONENT_WIDTH-1:0] im_abs_reg;
    logic [cmi_pkg::SUM_WIDTH-1:0]       re_sq_reg;
    logic [cmi_pkg::SUM_WIDTH-1:0]       im_sq_reg;
    logic [cmi_pkg::SUM_WIDTH-1:0]       sum_reg;
    logic [cmi_pkg::FRONT_STAGES-1:0]    valid_reg;

    // Magnitude of the most negative value still fits unsigned
    assign re_abs_next = real_part[cmi_pkg::COMPONENT_WIDTH-1]
                       ? (~real_part + 1'b1) : real_part;
    assign im_abs_next = imag_part[cmi_pkg::COMPONENT_WIDTH-1]
                       ? (~imag_part + 1'b1) : imag_part;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[cmi_pkg::FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        re_abs_reg <= re_abs_next;
        im_abs_reg <= im_abs_next;
        re_sq_reg  <= cmi_pkg::SUM_WIDTH'(re_abs_reg) * cmi_pkg::SUM_WIDTH'(re_abs_reg);
        im_sq_reg  <= cmi_pkg::SUM_WIDTH'(im_abs_reg) * cmi_pkg::SUM_WIDTH'(im_abs_reg);
        // Both squares top out at 2^(2W-2), so the sum fits 2W bits
        sum_reg    <= re_sq_reg + im_sq_reg;
    end

    assign stage_out.valid = valid_reg[cmi_pkg::FRONT_STAGES-1];
    assign stage_out.rem   = sum_reg;
    assign stage_out.root  = '0;
    assign stage_out.trial = cmi_pkg::TRIAL_START;

endmodule

// File: hdl/cmi_cell.sv
`timescale 1ns / 1ps

module cmi_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  cmi_pkg::stage_t stage_in,
    output cmi_pkg::stage_t stage_out
);

    logic [cmi_pkg::SUM_WIDTH:0]   try_sum;
    logic                          take;
    logic [cmi_pkg::SUM_WIDTH-1:0] rem_next;
    logic [cmi_pkg::SUM_WIDTH-1:0] root_next;
    logic                          valid_reg;
    logic [cmi_pkg::SUM_WIDTH-1:0] rem_reg;
    logic [cmi_pkg::SUM_WIDTH-1:0] root_reg;
    logic [cmi_pkg::SUM_WIDTH-1:0] trial_reg;

    // One restoring step: keep the bit if root+trial fits in the remainder
    always_comb
    begin
        try_sum   = {1'b0, stage_in.root} + {1'b0, stage_in.trial};
        take      = ({1'b0, stage_in.rem} >= try_sum);
        rem_next  = stage_in.rem;
        root_next = stage_in.root >> 1;
        if (take)
        begin
            rem_next  = stage_in.rem - try_sum[cmi_pkg::SUM_WIDTH-1:0];
            root_next = (stage_in.root >> 1) + stage_in.trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        trial_reg <= stage_in.trial >> 2;
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.rem   = rem_reg;
    assign stage_out.root  = root_reg;
    assign stage_out.trial = trial_reg;

endmodule

// File: hdl/complex_magnitude_isqrt.sv
`timescale 1ns / 1ps

// Complex magnitude: floor(sqrt(real_part^2 + imag_part^2)).
//
// Input channel: drive real_part / imag_part and pulse start. A transfer
//   happens on every rising edge where start is high and busy is low.
//   busy is held low: the pipeline takes a new bin every cycle.
// Output channel: magnitude is valid for one cycle while done is high.
//   There is no backpressure; the receiver must take it in that cycle.
// Pipeline: three front registers (abs, squares, sum) feed a chain of one
//   root cell per result bit; each cell does one compare-and-subtract
//   step.
// Throughput: one bin per clock, set by the fully pipelined cell chain.
// Reset: rst_n clears only the valid flags, so items in flight are
//   dropped and done stays low until new bins come through. No state
//   is kept between bins.

module complex_magnitude_isqrt
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    output logic                                        busy,
    input  logic signed [cmi_pkg::COMPONENT_WIDTH-1:0]  real_part,
    input  logic signed [cmi_pkg::COMPONENT_WIDTH-1:0]  imag_part,
    output logic                                        done,
    output logic        [cmi_pkg::COMPONENT_WIDTH-1:0]  magnitude
);

    // Link between neighbors; entry 0 comes from the squaring front end
    cmi_pkg::stage_t chain [0:cmi_pkg::CELL_COUNT];

    // Never stalls: every cycle can carry a new transfer
    assign busy = 1'b0;

    cmi_square u_square
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .real_part (real_part),
        .imag_part (imag_part),
        .stage_out (chain[0])
    );

    // One cell per root bit, trial bit moves down two places per cell
    for (genvar i = 0; i < cmi_pkg::CELL_COUNT; i++)
    begin : g_cell
        cmi_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    // The final root is below 2^COMPONENT_WIDTH
    assign done      = chain[cmi_pkg::CELL_COUNT].valid;
    assign magnitude = chain[cmi_pkg::CELL_COUNT].root[cmi_pkg::COMPONENT_WIDTH-1:0];

    // Every accepted bin yields a result at the end of the pipeline
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(cmi_pkg::LATENCY) done)
        else $error("accepted bin produced no result");

    // No result appears without a bin behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##(cmi_pkg::LATENCY) !done)
        else $error("result strobe without an accepted bin");

    // A zero bin gives a zero magnitude
    a_zero_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (start && real_part == '0 && imag_part == '0)
        |-> ##(cmi_pkg::LATENCY) (magnitude == '0))
        else $error("zero bin gave nonzero magnitude");

endmodule
